/* sv/rlsq_pkg.sv */
// Shared types and constants for the dial ring light sequencer.
// No dependencies; every other file imports this package.
package rlsq_pkg;

    // Lighting register addresses
    typedef enum logic [7:0] {
        REG_DIGIT_MODE   = 8'h10,
        REG_DIGIT_BRIGHT = 8'h20,
        REG_RING_ON      = 8'h40,
        REG_RING_BRIGHT  = 8'h41,
        REG_COLOUR       = 8'h50
    } reg_addr_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_LEVEL   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_SECONDS = CFG_INDEX_W'(1);

    localparam int LIMIT_W = 36;                  // 65535 * 1e6 < 2^36
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [6:0]  LEVEL_MAX = 7'd100;
    localparam logic [4:0]  NO_POS    = 5'd31;
    localparam logic [7:0]  BYTE_ALL  = 8'hFF;

    localparam logic [1:0] COUNT_ONE   = 2'd1;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    typedef struct packed {
        logic [6:0]         level;    // clamped to 0..100
        logic               sleep_en;
        logic [LIMIT_W-1:0] limit;    // idle limit in microseconds
    } cfg_t;

    // One poll's worth of writes, in compact form
    typedef struct packed {
        logic       dark;     // ring off, digits off
        logic       apply;    // full re-apply of on/brightness/mode
        logic       colour;   // colour write
        logic [6:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } batch_t;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [1:0] byte_count;
        logic       final_write;
    } write_t;

endpackage

/* sv/rlsq_if.sv */
// Channel interfaces: poll input, register write output, configuration writes.
// Depends on rlsq_pkg.
interface rlsq_poll_if #(parameter int TIME_WIDTH = 48);
    logic                  valid;
    logic                  ready;
    logic [3:0]            dial_position;
    logic [TIME_WIDTH-1:0] now_us;

    modport source (output valid, output dial_position, output now_us, input ready);
    modport sink   (input valid, input dial_position, input now_us, output ready);
endinterface

interface rlsq_write_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_address;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [1:0] byte_count;
    logic       final_write;

    modport source (output valid, output reg_address, output byte_zero, output byte_one,
                    output byte_two, output byte_count, output final_write, input ready);
    modport sink   (input valid, input reg_address, input byte_zero, input byte_one,
                    input byte_two, input byte_count, input final_write, output ready);
endinterface

interface rlsq_cfg_if;
    import rlsq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/dial_ring_light_sequencer_top.sv */
// Dial ring light sequencer, top level: config registers, idle-limit multiply,
// decision stage and write sequencer. Depends on rlsq_pkg, rlsq_if, rlsq_decide, rlsq_emit.
// The first write of a poll passes the poll input, batch holding and output registers.
// Throughput: one poll per cycle if it yields no write and the sequencer is free;
// otherwise one write per cycle unless wr.ready stalls; a poll yields up to 5 writes.
// Reset (rst_n, async, active low): lights not dark, awake, no position seen, level 0,
// sleep disabled; output empty.
module dial_ring_light_sequencer_top #(
    parameter int POSITIONS  = 16,
    parameter int TIME_WIDTH = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    rlsq_cfg_if.sink      cfg,
    rlsq_poll_if.sink     poll,
    rlsq_write_if.source  wr
);
    import rlsq_pkg::*;

    // Configuration registers, always ready: to be written only while idle; the block itself does not enforce it
    logic [6:0]            level_reg;
    logic [CFG_DATA_W-1:0] sleep_reg;
    // Idle limit in microseconds, loaded in the same cycle as sleep_reg
    logic [LIMIT_W-1:0]    limit_reg;
    logic [LIMIT_W-1:0]    limit_next;

    cfg_t   cfg_view;
    batch_t batch;
    logic   batch_push;
    logic   batch_ready;
    write_t wr_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            sleep_reg <= '1;          // -1: never sleep
            limit_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_LIGHT_LEVEL:   level_reg <= cfg.data[6:0];
                    CFG_SLEEP_SECONDS:
                    begin
                        sleep_reg <= cfg.data;
                        limit_reg <= limit_next;
                    end
                    default:           ;   // unknown index: ignored
                endcase
            end
        end
    end

    // 16 x 20 bit product of the incoming write; sign bit handled by sleep_en
    assign limit_next = LIMIT_W'(cfg.data[15:0]) * LIMIT_W'(US_PER_S);

    always_comb
    begin
        cfg_view.level    = (level_reg > LEVEL_MAX) ? LEVEL_MAX : level_reg;
        cfg_view.sleep_en = !sleep_reg[CFG_DATA_W-1];
        cfg_view.limit    = limit_reg;
    end

    rlsq_decide #(
        .POSITIONS  (POSITIONS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll        (poll),
        .cfg         (cfg_view),
        .batch_ready (batch_ready),
        .batch_push  (batch_push),
        .batch       (batch)
    );

    rlsq_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_push  (batch_push),
        .batch       (batch),
        .batch_ready (batch_ready),
        .wr_item     (wr_item),
        .wr_valid    (wr.valid),
        .wr_ready    (wr.ready)
    );

    assign wr.reg_address = wr_item.reg_address;
    assign wr.byte_zero   = wr_item.byte_zero;
    assign wr.byte_one    = wr_item.byte_one;
    assign wr.byte_two    = wr_item.byte_two;
    assign wr.byte_count  = wr_item.byte_count;
    assign wr.final_write = wr_item.final_write;
endmodule

/* sv/rlsq_decide.sv */
// Poll input register, lighting state and per-poll write decision.
// Depends on rlsq_pkg and rlsq_poll_if.
module rlsq_decide #(
    parameter int POSITIONS  = 16,
    parameter int TIME_WIDTH = 48
) (
    input  logic            clk,
    input  logic            rst_n,
    rlsq_poll_if.sink       poll,
    input  rlsq_pkg::cfg_t  cfg,
    input  logic            batch_ready,
    output logic            batch_push,
    output rlsq_pkg::batch_t batch
);
    import rlsq_pkg::*;

    localparam logic [3:0] POS_MAX = 4'(POSITIONS - 1);
    localparam int POS_IDX_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;

    // Hue sweep table, cyan at position 0 round to red at the top
    logic [23:0] colour_tab [POSITIONS];

    for (genvar p = 0; p < POSITIONS; p++) begin : g_colour
        localparam int HUE  = 240 - p * 240 / (POSITIONS - 1);
        localparam int SEG  = HUE / 60;
        localparam int RISE = (HUE % 60) * 255 / 60;
        localparam int FALL = 255 - RISE;
        localparam int RED  = (SEG == 0) ? 255 : (SEG == 1) ? FALL : 0;
        localparam int GRN  = (SEG == 0) ? RISE : (SEG >= 3) ? FALL : 255;
        localparam int BLU  = (SEG == 2) ? RISE : (SEG >= 3) ? 255 : 0;
        assign colour_tab[p] = {8'(RED), 8'(GRN), 8'(BLU)};
    end

    logic                  in_valid_reg;
    logic [3:0]            pos_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    logic                  dark_reg, dark_next;
    logic                  asleep_reg, asleep_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic [4:0]            seen_reg, seen_next;
    logic [6:0]            wlevel_reg, wlevel_next;
    logic [4:0]            wpos_reg, wpos_next;

    logic                  process;
    logic [3:0]            pos_c;
    logic [4:0]            pos_w;
    logic [TIME_WIDTH-1:0] idle;
    logic                  moved;
    logic                  go;
    logic [4:0]            wpos_eff;
    batch_t                b;

    assign process    = in_valid_reg && batch_ready;
    assign poll.ready = !in_valid_reg || process;

    always_comb
    begin
        pos_c = (pos_reg > POS_MAX) ? POS_MAX : pos_reg;
        pos_w = {1'b0, pos_c};
        idle  = (now_reg >= last_reg) ? (now_reg - last_reg) : '0;
        moved = (seen_reg != pos_w);

        dark_next   = dark_reg;
        asleep_next = asleep_reg;
        last_next   = last_reg;
        seen_next   = seen_reg;
        wlevel_next = wlevel_reg;
        wpos_next   = wpos_reg;
        wpos_eff    = wpos_reg;
        go          = 1'b0;

        b       = '0;
        b.level = cfg.level;
        {b.red, b.green, b.blue} = colour_tab[pos_c[POS_IDX_W-1:0]];

        if (cfg.level == '0)
        begin
            if (!dark_reg)
            begin
                b.dark    = 1'b1;
                dark_next = 1'b1;
                wpos_next = NO_POS;
            end
            asleep_next = 1'b0;
        end
        else
        begin
            seen_next = pos_w;
            if (moved)
            begin
                last_next = now_reg;
            end
            go = 1'b1;
            if (asleep_reg)
            begin
                if (!moved)
                begin
                    go = 1'b0;
                end
                else
                begin
                    asleep_next = 1'b0;
                end
            end
            else if (cfg.sleep_en && !moved && (CMP_W'(idle) > CMP_W'(cfg.limit)))
            begin
                b.dark      = 1'b1;
                dark_next   = 1'b1;
                asleep_next = 1'b1;
                go          = 1'b0;
            end

            if (go)
            begin
                if (dark_reg || (wlevel_reg != cfg.level))
                begin
                    b.apply     = 1'b1;
                    dark_next   = 1'b0;
                    wlevel_next = cfg.level;
                    wpos_eff    = NO_POS;
                end
                b.colour  = (wpos_eff != pos_w);
                wpos_next = pos_w;
            end
        end
    end

    assign batch      = b;
    assign batch_push = process && (b.dark || b.apply || b.colour);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            dark_reg     <= 1'b0;
            asleep_reg   <= 1'b0;
            last_reg     <= '0;
            seen_reg     <= NO_POS;
            wlevel_reg   <= '0;
            wpos_reg     <= NO_POS;
        end
        else
        begin
            if (poll.ready)
            begin
                in_valid_reg <= poll.valid;
            end
            if (process)
            begin
                dark_reg   <= dark_next;
                asleep_reg <= asleep_next;
                last_reg   <= last_next;
                seen_reg   <= seen_next;
                wlevel_reg <= wlevel_next;
                wpos_reg   <= wpos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            pos_reg <= poll.dial_position;
            now_reg <= poll.now_us;
        end
    end

    // Sleep only ever happens with the lights blanked
    a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
        asleep_reg |-> dark_reg)
        else $error("asleep without lights dark");

    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != NO_POS) |-> (seen_reg <= {1'b0, POS_MAX}))
        else $error("seen position out of range");

    a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
        batch_push |-> !(batch.dark && (batch.apply || batch.colour)))
        else $error("blanking batch mixed with lighting writes");
endmodule

/* sv/rlsq_emit.sv */
// Batch holding register and write sequencer with output register.
// Depends on rlsq_pkg.
module rlsq_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             batch_push,
    input  rlsq_pkg::batch_t batch,
    output logic             batch_ready,
    output rlsq_pkg::write_t wr_item,
    output logic             wr_valid,
    input  logic             wr_ready
);
    import rlsq_pkg::*;

    batch_t     batch_reg;
    logic       batch_valid_reg;
    logic [2:0] idx_reg;
    write_t     out_reg;
    logic       out_valid_reg;

    logic [2:0] total;
    logic       last;
    logic       load;
    write_t     cur;

    always_comb
    begin
        if (batch_reg.dark)
        begin
            total = 3'd2;
        end
        else if (batch_reg.apply)
        begin
            total = batch_reg.colour ? 3'd5 : 3'd4;
        end
        else
        begin
            total = 3'd1;
        end
    end

    assign last        = (idx_reg == total - 3'd1);
    assign load        = batch_valid_reg && (!out_valid_reg || wr_ready);
    assign batch_ready = !batch_valid_reg || (load && last);

    always_comb
    begin
        cur             = '0;
        cur.byte_count  = COUNT_ONE;
        cur.final_write = last;
        if (batch_reg.dark)
        begin
            cur.reg_address = (idx_reg == 3'd0) ? REG_RING_ON : REG_DIGIT_MODE;
        end
        else if (batch_reg.apply && (idx_reg < 3'd4))
        begin
            case (idx_reg[1:0])
                2'd0:
                begin
                    cur.reg_address = REG_RING_ON;
                    cur.byte_zero   = 8'd1;
                end
                2'd1:
                begin
                    cur.reg_address = REG_RING_BRIGHT;
                    cur.byte_zero   = {1'b0, batch_reg.level};
                end
                2'd2:
                begin
                    cur.reg_address = REG_DIGIT_MODE;
                    cur.byte_zero   = BYTE_ALL;
                end
                default:
                begin
                    cur.reg_address = REG_DIGIT_BRIGHT;
                    cur.byte_zero   = {1'b0, batch_reg.level};
                end
            endcase
        end
        else
        begin
            cur.reg_address = REG_COLOUR;
            cur.byte_zero   = batch_reg.red;
            cur.byte_one    = batch_reg.green;
            cur.byte_two    = batch_reg.blue;
            cur.byte_count  = COUNT_THREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_valid_reg <= 1'b0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (batch_push)
            begin
                batch_valid_reg <= 1'b1;
                idx_reg         <= '0;
            end
            else if (load && last)
            begin
                batch_valid_reg <= 1'b0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 3'd1;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wr_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_push)
        begin
            batch_reg <= batch;
        end
        if (load)
        begin
            out_reg <= cur;
        end
    end

    assign wr_item  = out_reg;
    assign wr_valid = out_valid_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        batch_valid_reg |-> (idx_reg < total))
        else $error("write index past end of batch");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        batch_push |-> batch_ready)
        else $error("batch overwritten while still pending");

    a_final_mark: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_reg.final_write == $past(last)))
        else $error("final write mark misplaced");
endmodule
